/* sv/m4ct_pkg.sv */
// m4ct_pkg: shared types, widths and codes of the 4x4 column transform
package m4ct_pkg;

	// element, result and index widths, lane and entry counts
	localparam int ELEM_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int IN_W       = 32;
	localparam int OUT_W      = 32;
	localparam int N_LANES    = 4;
	localparam int COL_W      = 2;
	localparam int IDX_W      = 2 * COL_W;
	localparam int N_ENTRIES  = N_LANES * N_LANES;

	// product, pair sum and full lane sum widths
	localparam int PROD_W = 2 * ELEM_WIDTH;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;

	typedef logic signed [ELEM_WIDTH-1:0] elem_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [PAIR_W-1:0]     pair_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic signed [OUT_W-1:0]      res_t;
	typedef logic [COL_W-1:0]             col_t;

	// word kinds
	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_XFORM = 1'b1
	} action_t;

	// stage load enables shared by all lanes
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} pipe_ctl_t;

endpackage

/* sv/m4ct_lane.sv */
// m4ct_lane: one row lane, four products, pair sums and the full dot product
module m4ct_lane (
	input  logic                  clk,
	input  m4ct_pkg::pipe_ctl_t   ctl,
	input  m4ct_pkg::elem_t       a_row [m4ct_pkg::N_LANES],
	input  m4ct_pkg::elem_t       b_col [m4ct_pkg::N_LANES],
	output m4ct_pkg::sum_t        sum_s3
);
	import m4ct_pkg::*;

	prod_t prod_s1 [N_LANES];
	pair_t pair_s2 [N_LANES/2];

	// one multiplier per term
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			for (int k = 0; k < N_LANES; k++) begin
				prod_s1[k] <= PROD_W'(a_row[k]) * PROD_W'(b_col[k]);
			end
		end
	end

	// pairwise sums
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			for (int p = 0; p < N_LANES/2; p++) begin
				pair_s2[p] <= PAIR_W'(prod_s1[2*p]) + PAIR_W'(prod_s1[2*p+1]);
			end
		end
	end

	// exact lane sum
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			sum_s3 <= SUM_W'(pair_s2[0]) + SUM_W'(pair_s2[1]);
		end
	end

endmodule

/* sv/m4ct_merge.sv */
// m4ct_merge: scales and saturates the lane sums, merges overflow, holds the result word
module m4ct_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s3,
	input  m4ct_pkg::col_t       column_s3,
	input  m4ct_pkg::sum_t       sum_s3 [m4ct_pkg::N_LANES],
	input  logic                 out_stall,
	output logic                 en_out,
	output logic                 out_valid,
	output m4ct_pkg::col_t       out_column,
	output m4ct_pkg::res_t       res_q [m4ct_pkg::N_LANES],
	output logic                 overflow
);
	import m4ct_pkg::*;

	localparam elem_t ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
	localparam elem_t ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

	res_t res_d [N_LANES];
	logic sat_any;

	// result register is free or being drained
	assign en_out = !out_valid || !out_stall;

	// floor shift, range check and clamp per lane
	always_comb begin
		sum_t  sh;
		elem_t val;
		logic  all_one;
		logic  all_zero;
		sat_any = 1'b0;
		for (int r = 0; r < N_LANES; r++) begin
			sh       = sum_s3[r] >>> FRAC_BITS;
			all_one  = &sh[SUM_W-1:ELEM_WIDTH-1];
			all_zero = ~|sh[SUM_W-1:ELEM_WIDTH-1];
			val      = sh[ELEM_WIDTH-1:0];
			if (!all_one && !all_zero) begin
				sat_any = 1'b1;
				val     = sh[SUM_W-1] ? ELEM_MIN : ELEM_MAX;
			end
			res_d[r] = OUT_W'(val);
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= valid_s3;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (en_out) begin
			out_column <= column_s3;
			overflow   <= sat_any;
			for (int r = 0; r < N_LANES; r++) begin
				res_q[r] <= res_d[r];
			end
		end
	end

endmodule

/* sv/matrix4_column_transform_top.sv */
// matrix4_column_transform_top: stored left matrix, four product lanes and result merge
//
//  channel | valid     | stall     | fields
//  --------+-----------+-----------+-------------------------------------------
//  input   | in_valid  | in_stall  | action, column, in_0..in_3
//  output  | out_valid | out_stall | out_column, out_0..out_3, overflow
//
// one word per cycle is taken while in_stall is low; a transform word's products register
// at acceptance, then the pair add, the lane add and the saturation into the result
// register follow in that order, and the result word is valid once it is in that register
// a load word writes its column of the stored matrix at acceptance and gives no result
// reset clears the stored matrix to zero and empties the pipeline
// out_stall holds the result register; stages behind it keep filling bubbles and
// in_stall rises only when every stage holds a word
module matrix4_column_transform_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    action,
	input  logic [m4ct_pkg::COL_W-1:0] column,
	input  logic signed [m4ct_pkg::IN_W-1:0] in_0,
	input  logic signed [m4ct_pkg::IN_W-1:0] in_1,
	input  logic signed [m4ct_pkg::IN_W-1:0] in_2,
	input  logic signed [m4ct_pkg::IN_W-1:0] in_3,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [m4ct_pkg::COL_W-1:0] out_column,
	output logic signed [m4ct_pkg::OUT_W-1:0] out_0,
	output logic signed [m4ct_pkg::OUT_W-1:0] out_1,
	output logic signed [m4ct_pkg::OUT_W-1:0] out_2,
	output logic signed [m4ct_pkg::OUT_W-1:0] out_3,
	output logic                    overflow
);
	import m4ct_pkg::*;

	elem_t     a_q [N_ENTRIES];
	elem_t     b_col [N_LANES];
	elem_t     a_row [N_LANES][N_LANES];
	sum_t      sum_s3 [N_LANES];
	res_t      res_q [N_LANES];
	pipe_ctl_t ctl;
	logic      en_out;
	logic      accept;
	logic      valid_s1, valid_s2, valid_s3;
	col_t      column_s1, column_s2, column_s3;

	// stage enables: a stage loads when empty or when the next one loads
	always_comb begin
		ctl.en_s3 = !valid_s3 || en_out;
		ctl.en_s2 = !valid_s2 || ctl.en_s3;
		ctl.en_s1 = !valid_s1 || ctl.en_s2;
	end

	assign in_stall = !ctl.en_s1;
	assign accept   = in_valid && !in_stall;

	// incoming column, low element bits as signed values
	assign b_col[0] = in_0[ELEM_WIDTH-1:0];
	assign b_col[1] = in_1[ELEM_WIDTH-1:0];
	assign b_col[2] = in_2[ELEM_WIDTH-1:0];
	assign b_col[3] = in_3[ELEM_WIDTH-1:0];

	// stored left matrix, entry column*4+row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_ENTRIES; i++) begin
				a_q[i] <= '0;
			end
		end else if (accept && action == ACT_LOAD) begin
			for (int r = 0; r < N_LANES; r++) begin
				a_q[{column, COL_W'(r)}] <= b_col[r];
			end
		end
	end

	// row r of the stored matrix feeds lane r
	always_comb begin
		for (int r = 0; r < N_LANES; r++) begin
			for (int k = 0; k < N_LANES; k++) begin
				a_row[r][k] = a_q[{COL_W'(k), COL_W'(r)}];
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ctl.en_s1) valid_s1 <= accept && action == ACT_XFORM;
			if (ctl.en_s2) valid_s2 <= valid_s1;
			if (ctl.en_s3) valid_s3 <= valid_s2;
		end
	end

	// column index travels with the word
	always_ff @(posedge clk) begin
		if (ctl.en_s1) column_s1 <= column;
		if (ctl.en_s2) column_s2 <= column_s1;
		if (ctl.en_s3) column_s3 <= column_s2;
	end

	// product lanes
	for (genvar r = 0; r < N_LANES; r++) begin : g_lane
		m4ct_lane u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.a_row  (a_row[r]),
			.b_col  (b_col),
			.sum_s3 (sum_s3[r])
		);
	end

	// saturation and result register
	m4ct_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s3   (valid_s3),
		.column_s3  (column_s3),
		.sum_s3     (sum_s3),
		.out_stall  (out_stall),
		.en_out     (en_out),
		.out_valid  (out_valid),
		.out_column (out_column),
		.res_q      (res_q),
		.overflow   (overflow)
	);

	assign out_0 = res_q[0];
	assign out_1 = res_q[1];
	assign out_2 = res_q[2];
	assign out_3 = res_q[3];

`ifndef SYNTH
	// a load word never enters the product pipeline
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_LOAD |=> !valid_s1)
		else $error("load word entered the product pipeline");

	// a transform word enters stage one with its column
	a_xform_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_XFORM |=> valid_s1 && column_s1 == $past(column))
		else $error("transform word lost at stage one");

	// input is held off only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && valid_s3 && out_valid)
		else $error("input stalled with a free stage");

	// a held result word keeps its column
	a_held_column: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_column))
		else $error("held result word changed");
`endif

endmodule

/* dv/m4ct_check_pkg.sv */
// m4ct_check_pkg: column product predictor and result scoreboard for the column transform
`timescale 1ns / 1ps

package m4ct_check_pkg;
	import m4ct_pkg::*;

	typedef logic [N_LANES-1:0][IN_W-1:0]  in_lanes_t;
	typedef logic [N_LANES-1:0][OUT_W-1:0] out_lanes_t;
	typedef logic signed [95:0]            wide_t;

	// one predicted product column
	typedef struct packed {
		col_t       column;
		out_lanes_t lanes;
		logic       ovf;
	} product_col_t;

	class product_checker;
		elem_t        left_cols [N_ENTRIES];
		product_col_t product_queue [$];
		int           errors;
		int           n_loads;
		int           n_xforms;
		int           n_checked;
		int           n_saturated;

		function new();
			foreach (left_cols[i]) left_cols[i] = '0;
			errors      = 0;
			n_loads     = 0;
			n_xforms    = 0;
			n_checked   = 0;
			n_saturated = 0;
		endfunction

		function int pending();
			return product_queue.size();
		endfunction

		// exact lane sum, floor shift, saturate to the element range
		function product_col_t predict_product_column(col_t col, in_lanes_t rhs);
			product_col_t res;
			wide_t        acc;
			wide_t        wa;
			wide_t        wb;
			wide_t        lim_hi;
			wide_t        lim_lo;
			lim_hi     = (wide_t'(1) <<< (ELEM_WIDTH - 1)) - wide_t'(1);
			lim_lo     = -lim_hi - wide_t'(1);
			res.column = col;
			res.ovf    = 1'b0;
			for (int r = 0; r < N_LANES; r++) begin
				acc = '0;
				for (int k = 0; k < N_LANES; k++) begin
					wa  = left_cols[k * N_LANES + r];
					wb  = elem_t'(rhs[k]);
					acc = acc + wa * wb;
				end
				acc = acc >>> FRAC_BITS;
				if (acc > lim_hi) begin
					acc     = lim_hi;
					res.ovf = 1'b1;
				end else if (acc < lim_lo) begin
					acc     = lim_lo;
					res.ovf = 1'b1;
				end
				res.lanes[r] = acc[OUT_W-1:0];
			end
			return res;
		endfunction

		// accepted input word: store a column or queue its product
		function void note_word(action_t act, col_t col, in_lanes_t data);
			if (act == ACT_LOAD) begin
				for (int r = 0; r < N_LANES; r++)
					left_cols[col * N_LANES + r] = elem_t'(data[r]);
				n_loads++;
			end else begin
				product_queue.push_back(predict_product_column(col, data));
				n_xforms++;
			end
		endfunction

		// accepted result word against the oldest prediction
		function void check_word(col_t col, out_lanes_t lanes, logic ovf);
			product_col_t want;
			if (product_queue.size() == 0) begin
				$display("%0t: result word with nothing pending: column %0d lanes %h ovf %b",
					$time, col, lanes, ovf);
				errors++;
				return;
			end
			want = product_queue.pop_front();
			n_checked++;
			if (want.ovf) n_saturated++;
			if (col !== want.column) begin
				$display("%0t: out_column expected %0d actual %0d", $time, want.column, col);
				errors++;
			end
			for (int r = 0; r < N_LANES; r++) begin
				if (lanes[r] !== want.lanes[r]) begin
					$display("%0t: column %0d out_%0d expected %h actual %h",
						$time, want.column, r, want.lanes[r], lanes[r]);
					errors++;
				end
			end
			if (ovf !== want.ovf) begin
				$display("%0t: column %0d overflow expected %b actual %b",
					$time, want.column, want.ovf, ovf);
				errors++;
			end
		endfunction
	endclass

endpackage

/* dv/testbench.sv */
// testbench: random and directed column stream check of matrix4_column_transform_top
`timescale 1ns / 1ps

module testbench;
	import m4ct_pkg::*;
	import m4ct_check_pkg::*;

	localparam int N_WORDS   = 1700;
	localparam int QUIET_AT  = 1550;
	localparam int LIMIT_NS  = 2_000_000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic              action    = ACT_LOAD;
	col_t              column    = '0;
	logic signed [IN_W-1:0]  in_0 = '0;
	logic signed [IN_W-1:0]  in_1 = '0;
	logic signed [IN_W-1:0]  in_2 = '0;
	logic signed [IN_W-1:0]  in_3 = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	col_t              out_column;
	logic signed [OUT_W-1:0] out_0;
	logic signed [OUT_W-1:0] out_1;
	logic signed [OUT_W-1:0] out_2;
	logic signed [OUT_W-1:0] out_3;
	logic              overflow;

	product_checker sb;
	logic quiet      = 1'b0;
	int   idle_pct   = 0;
	int   stall_pct  = 30;
	int   stall_hold = 0;
	int   n_sent     = 0;
	int   n_drains   = 0;

	matrix4_column_transform_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.column    (column),
		.in_0      (in_0),
		.in_1      (in_1),
		.in_2      (in_2),
		.in_3      (in_3),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_column(out_column),
		.out_0     (out_0),
		.out_1     (out_1),
		.out_2     (out_2),
		.out_3     (out_3),
		.overflow  (overflow)
	);

	// clock
	always #4 clk = ~clk;

	// watch both channels at the edge
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (in_valid && !in_stall)
				sb.note_word(action_t'(action), column, {in_3, in_2, in_1, in_0});
			if (out_valid && !out_stall)
				sb.check_word(out_column, {out_3, out_2, out_1, out_0}, overflow);
		end
	end

	// receiver stalls in bursts, rate changes from stretch to stretch
	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			out_stall  <= 1'b0;
			stall_hold <= 0;
		end else if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (out_stall) begin
			out_stall  <= 1'b0;
			stall_hold <= $urandom_range(0, 12);
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_stall  <= 1'b1;
			stall_hold <= $urandom_range(0, 8);
		end else if ($urandom_range(0, 63) == 0) begin
			case ($urandom_range(0, 4))
				0, 1: stall_pct <= 0;
				2: stall_pct <= 15;
				3: stall_pct <= 40;
				default: stall_pct <= 70;
			endcase
		end
	end

	// random element: small q16.16, full range or an extreme value
	function automatic logic [IN_W-1:0] rand_elem(int flavor);
		int f;
		f = (flavor == 3) ? int'($urandom_range(0, 2)) : flavor;
		case (f)
			0: return IN_W'(int'($urandom_range(0, 524288)) - 262144);
			1: return $urandom;
			default: begin
				case ($urandom_range(0, 6))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					4: return 32'h0000_0001;
					5: return 32'h0001_0000;
					default: return 32'hFFFF_0000;
				endcase
			end
		endcase
	endfunction

	function automatic in_lanes_t rand_lanes(int flavor);
		in_lanes_t v;
		for (int r = 0; r < N_LANES; r++) v[r] = rand_elem(flavor);
		return v;
	endfunction

	// one input word, with an optional idle burst ahead of it
	task automatic send_word(action_t act, col_t col, in_lanes_t data);
		if (idle_pct != 0 && !quiet && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		column   <= col;
		in_0     <= data[0];
		in_1     <= data[1];
		in_2     <= data[2];
		in_3     <= data[3];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
	endtask

	// hold the sender until every pending product has come out
	task automatic drain_products();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		n_drains++;
	endtask

	task automatic load_all(logic [IN_W-1:0] v);
		for (int c = 0; c < N_LANES; c++) send_word(ACT_LOAD, col_t'(c), {4{v}});
	endtask

	// stimulus
	initial begin
		int        kind;
		int        flavor;
		int        n;
		int        first;
		in_lanes_t ident;

		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stored matrix is zero after reset
		send_word(ACT_XFORM, 2'd0, {32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});

		// identity passes columns through untouched
		for (int c = 0; c < N_LANES; c++) begin
			ident    = '0;
			ident[c] = 32'h0001_0000;
			send_word(ACT_LOAD, col_t'(c), ident);
		end
		send_word(ACT_XFORM, 2'd1, {32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF});

		// tiny negative products floor to minus one
		send_word(ACT_LOAD, 2'd0, {32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001});
		send_word(ACT_XFORM, 2'd3, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001});

		// largest positive operands saturate both ways
		load_all(32'h7FFF_FFFF);
		send_word(ACT_XFORM, 2'd0, {4{32'h7FFF_FFFF}});
		send_word(ACT_XFORM, 2'd1, {4{32'h8000_0000}});

		// most negative operands: positive saturation, then a sum that cancels
		load_all(32'h8000_0000);
		send_word(ACT_XFORM, 2'd2, {4{32'h8000_0000}});
		send_word(ACT_XFORM, 2'd3, {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
		drain_products();

		// random part: mostly full matrix products, some loose transforms and noise
		while (n_sent < N_WORDS) begin
			if (n_sent >= QUIET_AT) begin
				quiet    <= 1'b1;
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 10;
					2: idle_pct = 30;
					default: idle_pct = 60;
				endcase
			end
			kind   = $urandom_range(0, 9);
			flavor = $urandom_range(0, 3);
			if (kind <= 6) begin
				for (int c = 0; c < N_LANES; c++)
					send_word(ACT_LOAD, col_t'(c), rand_lanes(flavor));
				first = $urandom_range(0, 3);
				for (int c = 0; c < N_LANES; c++)
					send_word(ACT_XFORM, col_t'((first + c) % N_LANES),
						rand_lanes($urandom_range(0, 3)));
			end else if (kind <= 8) begin
				n = $urandom_range(1, 6);
				repeat (n) send_word(ACT_XFORM, col_t'($urandom_range(0, 3)), rand_lanes(flavor));
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) send_word(action_t'($urandom_range(0, 1)),
					col_t'($urandom_range(0, 3)), rand_lanes(flavor));
			end
			if (!quiet && $urandom_range(0, 39) == 0) drain_products();
		end

		// let the pipeline empty, then keep idling to catch strays
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d words: %0d column loads, %0d transforms, %0d drains",
			n_sent, sb.n_loads, sb.n_xforms, n_drains);
		$display("checked %0d product columns, %0d of them saturated",
			sb.n_checked, sb.n_saturated);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_NS);
		$display("watchdog expired at %0t", $time);
		$display("Some tests failed");
		$finish;
	end

endmodule
